[rtl/sort_rows_by_row_min_desc_macros.svh]
// Assertion macros used by the row sorter RTL.
`ifndef SORT_ROWS_BY_ROW_MIN_DESC_MACROS_SVH
`define SORT_ROWS_BY_ROW_MIN_DESC_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication: cons holds whenever ante holds.
`define SRMD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("row sorter: implication check failed");
// Next-cycle implication: cons holds in the cycle after ante.
`define SRMD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("row sorter: next-cycle check failed");
`else
`define SRMD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SRMD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/sortrm_pkg.sv]
// Types and constants of the row sorter.
package sortrm_pkg;
   localparam int MAX_ROWS   = 8;
   localparam int MAX_COLS   = 8;
   localparam int CELLS      = MAX_ROWS * MAX_COLS;
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);
   localparam int COL_CNT_W  = $clog2(MAX_COLS + 1);
   localparam int CELL_AW    = $clog2(CELLS);
   localparam int CELL_CNT_W = $clog2(CELLS + 1);
   localparam int ELEM_W     = 32;
   localparam int CSR_DW     = 4;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLS = 1'b1;

   // One sort slot: a row's key and the row's place in the store.
   typedef struct packed {
      logic signed [ELEM_W-1:0] key;
      logic [ROW_W-1:0]         row;
   } slot_type;
endpackage

[rtl/sort_rows_by_row_min_desc.sv]
// Row sorter: sorts matrix rows by row minimum, largest first, and streams them out.
// Load: one beat per cycle; each row's minimum is tracked as its elements arrive.
// Sort: a selection sort over the row keys, one key compare per scan cycle on the shared comparator.
// Emit: each beat takes a registered matrix store read, then an output register load that waits for the receiver.
// req_ready is low from the last loaded beat until the final result beat is registered; with
// a zero size beats are taken and dropped. Reset (sync, high) clears control and sizes only.
`include "sort_rows_by_row_min_desc_macros.svh"
module sort_rows_by_row_min_desc (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [sortrm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sortrm_pkg::CSR_DW-1:0]        csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [sortrm_pkg::ELEM_W-1:0] req_element,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [sortrm_pkg::ELEM_W-1:0] rsp_element_res,
   output logic                                 rsp_last
);
   import sortrm_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SEL_INIT,
      ST_SEL_SCAN,
      ST_SWAP_I,
      ST_SWAP_B,
      ST_EMIT_RD,
      ST_EMIT_PUT
   } state_type;

   // Control and sequencer registers.
   state_type                state_ff, state_in;
   logic [CSR_DW-1:0]        num_rows_ff, num_rows_in;
   logic [CSR_DW-1:0]        num_cols_ff, num_cols_in;
   logic [CELL_CNT_W-1:0]    load_count_ff, load_count_in;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic [COL_W-1:0]         col_ff, col_in;
   logic [ROW_W-1:0]         i_ff, i_in;
   logic [ROW_CNT_W-1:0]     j_ff, j_in;
   logic [ROW_W-1:0]         p_ff, p_in;
   logic [COL_W-1:0]         c_ff, c_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic signed [ELEM_W-1:0] run_min_ff, run_min_in;
   slot_type                 best_ff, best_in;
   logic [ROW_W-1:0]         best_pos_ff, best_pos_in;
   slot_type                 save_ff, save_in;
   logic signed [ELEM_W-1:0] rsp_elem_ff, rsp_elem_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic signed [ELEM_W-1:0] rd_q_ff;

   // Storage: the matrix as loaded (never moved) and the slot table that carries the order.
   logic signed [ELEM_W-1:0] matrix_ff [CELLS];
   slot_type                 slot_ff [MAX_ROWS];

   logic [ROW_CNT_W-1:0]     rows_eff;
   logic [COL_CNT_W-1:0]     cols_eff;
   logic [CELL_CNT_W-1:0]    total;
   logic                     req_take;
   logic                     load_take;
   logic                     rsp_take;
   logic [ROW_W-1:0]         slot_ra;
   slot_type                 slot_rd;
   logic                     slot_we;
   logic [ROW_W-1:0]         slot_wa;
   slot_type                 slot_wd;
   logic signed [ELEM_W-1:0] cmp_a;
   logic signed [ELEM_W-1:0] cmp_b;
   logic                     cmp_lt;
   logic signed [ELEM_W-1:0] key_new;
   logic                     col_last;
   logic                     load_last;
   logic [ROW_W+COL_CNT_W-1:0] row_base;
   logic [CELL_AW-1:0]       emit_addr;
   logic                     emit_last;
   logic                     col_last_emit;

   // Clamp counts above the store size.
   assign rows_eff = (num_rows_ff > MAX_ROWS) ? ROW_CNT_W'(MAX_ROWS) : ROW_CNT_W'(num_rows_ff);
   assign cols_eff = (num_cols_ff > MAX_COLS) ? COL_CNT_W'(MAX_COLS) : COL_CNT_W'(num_cols_ff);
   assign total    = CELL_CNT_W'(rows_eff * cols_eff);

   // Always take beats while loading; drop them when either size is zero.
   assign req_ready = (state_ff == ST_LOAD);
   assign req_take  = req_valid && req_ready;
   assign load_take = req_take && (total != '0);
   assign rsp_take  = rsp_valid_ff && rsp_ready;

   // Single slot read port: row i at selection start, row j while scanning, position p on emit.
   always_comb begin
      case (state_ff)
         ST_SEL_INIT: slot_ra = i_ff;
         ST_SEL_SCAN: slot_ra = j_ff[ROW_W-1:0];
         default:     slot_ra = p_ff;
      endcase
   end
   assign slot_rd = slot_ff[slot_ra];

   // Shared signed comparator: running minimum on load, best key against candidate on scan.
   always_comb begin
      if (state_ff == ST_SEL_SCAN) begin
         cmp_a = best_ff.key;
         cmp_b = slot_rd.key;
      end else begin
         cmp_a = req_element;
         cmp_b = run_min_ff;
      end
   end
   assign cmp_lt = cmp_a < cmp_b;

   assign key_new   = ((col_ff == '0) || cmp_lt) ? req_element : run_min_ff;
   assign col_last  = (COL_CNT_W'(col_ff) == cols_eff - 1'b1);
   assign load_last = (load_count_ff + 1'b1 == total);

   // Emit address: the row held at position p, column c.
   assign row_base  = slot_rd.row * cols_eff;
   assign emit_addr = CELL_AW'(row_base) + CELL_AW'(c_ff);
   assign emit_last = (ROW_CNT_W'(p_ff) == rows_eff - 1'b1) && col_last_emit;

   assign col_last_emit = (COL_CNT_W'(c_ff) == cols_eff - 1'b1);

   always_comb begin
      state_in      = state_ff;
      num_rows_in   = num_rows_ff;
      num_cols_in   = num_cols_ff;
      load_count_in = load_count_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      p_in          = p_ff;
      c_in          = c_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_take;
      run_min_in    = run_min_ff;
      best_in       = best_ff;
      best_pos_in   = best_pos_ff;
      save_in       = save_ff;
      rsp_elem_in   = rsp_elem_ff;
      rsp_last_in   = rsp_last_ff;
      slot_we       = 1'b0;
      slot_wa       = row_ff;
      slot_wd       = '{key: key_new, row: row_ff};

      case (state_ff)
         ST_LOAD: begin
            if (load_take) begin
               run_min_in    = key_new;
               load_count_in = load_count_ff + 1'b1;
               if (col_last) begin
                  // Row complete: file its key under its own row number.
                  slot_we = 1'b1;
                  col_in  = '0;
                  row_in  = row_ff + 1'b1;
               end else begin
                  col_in  = col_ff + 1'b1;
               end
               if (load_last) begin
                  load_count_in = '0;
                  row_in        = '0;
                  col_in        = '0;
                  i_in          = '0;
                  state_in      = ST_SEL_INIT;
               end
            end
         end
         ST_SEL_INIT: begin
            best_in     = slot_rd;
            save_in     = slot_rd;
            best_pos_in = i_ff;
            j_in        = ROW_CNT_W'(i_ff) + 1'b1;
            state_in    = ST_SEL_SCAN;
         end
         ST_SEL_SCAN: begin
            if (j_ff == rows_eff) begin
               state_in = ST_SWAP_I;
            end else begin
               // Strictly larger key wins, so the first of equal keys stays.
               if (cmp_lt) begin
                  best_in     = slot_rd;
                  best_pos_in = j_ff[ROW_W-1:0];
               end
               j_in = j_ff + 1'b1;
            end
         end
         ST_SWAP_I: begin
            slot_we  = 1'b1;
            slot_wa  = i_ff;
            slot_wd  = best_ff;
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            slot_we = 1'b1;
            slot_wa = best_pos_ff;
            slot_wd = save_ff;
            if (ROW_CNT_W'(i_ff) == rows_eff - 1'b1) begin
               p_in     = '0;
               c_in     = '0;
               state_in = ST_EMIT_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SEL_INIT;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_PUT;
         end
         ST_EMIT_PUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_elem_in  = rd_q_ff;
               rsp_last_in  = emit_last;
               if (emit_last) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_EMIT_RD;
                  if (col_last_emit) begin
                     c_in = '0;
                     p_in = p_ff + 1'b1;
                  end else begin
                     c_in = c_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // Size writes restart loading.
      if (csr_wr_en) begin
         if (csr_index == REG_NUM_ROWS) begin
            num_rows_in = csr_wdata;
         end else if (csr_index == REG_NUM_COLS) begin
            num_cols_in = csr_wdata;
         end
         load_count_in = '0;
         row_in        = '0;
         col_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         num_rows_ff   <= '0;
         num_cols_ff   <= '0;
         load_count_ff <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         p_ff          <= '0;
         c_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_rows_ff   <= num_rows_in;
         num_cols_ff   <= num_cols_in;
         load_count_ff <= load_count_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         p_ff          <= p_in;
         c_ff          <= c_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      run_min_ff  <= run_min_in;
      best_ff     <= best_in;
      best_pos_ff <= best_pos_in;
      save_ff     <= save_in;
      rsp_elem_ff <= rsp_elem_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Matrix store: write on each loaded beat, registered read for emit.
   always_ff @(posedge clock) begin
      if (load_take) begin
         matrix_ff[load_count_ff[CELL_AW-1:0]] <= req_element;
      end
      rd_q_ff <= matrix_ff[emit_addr];
   end

   // Slot table: one write port shared by key filing and the swap steps.
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_ff[slot_wa] <= slot_wd;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_element_res = rsp_elem_ff;
   assign rsp_last        = rsp_last_ff;

   // The final loaded beat hands over to the sort.
   `SRMD_ASSERT_NXT(a_load_to_sort, clock, reset, load_take && load_last && !csr_wr_en, state_ff == ST_SEL_INIT)
   // The scan index never passes the row count and always sits past the position being filled.
   `SRMD_ASSERT_IMP(a_scan_range, clock, reset, state_ff == ST_SEL_SCAN, (j_ff <= rows_eff) && (j_ff > ROW_CNT_W'(i_ff)))
   // The chosen row lies at or after the position it is swapped into.
   `SRMD_ASSERT_IMP(a_best_order, clock, reset, state_ff == ST_SWAP_B, best_pos_ff >= i_ff)
   // Input is refused for the whole sort and emit.
   `SRMD_ASSERT_IMP(a_busy_no_ready, clock, reset, state_ff != ST_LOAD, !req_ready)
   // The final beat sends the sequencer back to loading.
   `SRMD_ASSERT_NXT(a_last_to_load, clock, reset, (state_ff == ST_EMIT_PUT) && (!rsp_valid_ff || rsp_ready) && emit_last, (state_ff == ST_LOAD) && rsp_valid && rsp_last)
endmodule

[verif/sort_rows_by_row_min_desc_test.sv]
// Self-checking testbench for the row sorter: matrices in, rows sorted by minimum out.
`timescale 1ns / 100ps

module sort_rows_by_row_min_desc_test;
   import sortrm_pkg::*;

   localparam logic signed [ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;
   localparam logic signed [ELEM_W-1:0] ELEM_MAX = 32'sh7FFF_FFFF;
   localparam int RANDOM_ITEMS = 240;
   // Idle time before a register write and after the last expected beat.
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 60;

   // One expected output beat of the sorted matrix.
   typedef struct {
      logic signed [ELEM_W-1:0] element;
      logic                     last;
   } sorted_beat_type;

   // Shadow copy of the sorter: loads elements, sorts rows on the final one and
   // queues the beats that the block must emit.
   class row_order_board;
      logic [CSR_DW-1:0]        row_count = '0;
      logic [CSR_DW-1:0]        col_count = '0;
      int unsigned              fill = 0;
      logic signed [ELEM_W-1:0] cells [CELLS];
      logic signed [ELEM_W-1:0] row_mins [MAX_ROWS];
      sorted_beat_type          beats_due [$];
      int unsigned              errors = 0;
      int unsigned              matrices_sorted = 0;
      int unsigned              beats_checked = 0;

      // Any write to a size register restarts loading.
      function void set_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DW-1:0] value);
         case (index)
            REG_NUM_ROWS: begin
               row_count = value;
               fill = 0;
            end
            REG_NUM_COLS: begin
               col_count = value;
               fill = 0;
            end
            default: ;
         endcase
      endfunction

      function void take_element(logic signed [ELEM_W-1:0] value);
         int unsigned              rows;
         int unsigned              cols;
         int unsigned              total;
         int unsigned              best;
         logic signed [ELEM_W-1:0] held;
         sorted_beat_type          beat;
         rows  = (row_count > MAX_ROWS) ? MAX_ROWS : row_count;
         cols  = (col_count > MAX_COLS) ? MAX_COLS : col_count;
         total = rows * cols;
         if (total == 0) return;
         if (fill >= total) fill = 0;
         cells[fill] = value;
         fill++;
         if (fill < total) return;
         for (int r = 0; r < rows; r++) begin
            row_mins[r] = cells[r * cols];
            for (int c = 1; c < cols; c++)
               if (cells[r * cols + c] < row_mins[r]) row_mins[r] = cells[r * cols + c];
         end
         // Selection sort, largest minimum first; first of equal keys wins.
         for (int i = 0; i < rows; i++) begin
            best = i;
            for (int j = i + 1; j < rows; j++)
               if (row_mins[best] < row_mins[j]) best = j;
            for (int c = 0; c < cols; c++) begin
               held = cells[best * cols + c];
               cells[best * cols + c] = cells[i * cols + c];
               cells[i * cols + c] = held;
            end
            held = row_mins[best];
            row_mins[best] = row_mins[i];
            row_mins[i] = held;
         end
         for (int k = 0; k < total; k++) begin
            beat.element = cells[k];
            beat.last    = (k == total - 1);
            beats_due.push_back(beat);
         end
         fill = 0;
         matrices_sorted++;
      endfunction

      function void check_beat(logic signed [ELEM_W-1:0] element, logic last);
         sorted_beat_type want;
         if (beats_due.size() == 0) begin
            $error("unexpected result beat: element_res %0d last %0b", element, last);
            errors++;
            return;
         end
         want = beats_due.pop_front();
         beats_checked++;
         if (element !== want.element) begin
            $error("element_res mismatch: expected %0d, got %0d", want.element, element);
            errors++;
         end
         if (last !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DW-1:0]        csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [ELEM_W-1:0] req_element = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [ELEM_W-1:0] rsp_element_res;
   logic                     rsp_last;

   row_order_board board = new;

   int unsigned burst_left = 0;
   int unsigned elements_sent = 0;
   int unsigned settings_used = 0;
   logic [4:0]  stall_step = '0;
   logic [31:0] stall_mask = '0;

   sort_rows_by_row_min_desc dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_element     (req_element),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_element_res (rsp_element_res),
      .rsp_last        (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 0;
   end

   // Receiver: walk a 32-bit stall mask bit by bit, pick a fresh one each lap. The
   // masks range from no stalls at all to mostly stalled.
   always @(posedge clock) begin
      stall_step <= stall_step + 1'b1;
      if (stall_step == '0) begin
         case ($urandom_range(0, 3))
            0: stall_mask <= '0;
            1: stall_mask <= $urandom;
            2: stall_mask <= $urandom & $urandom;
            default: stall_mask <= $urandom | $urandom;
         endcase
      end
      rsp_ready <= !stall_mask[stall_step];
   end

   // Check every accepted result beat against the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_beat(rsp_element_res, rsp_last);
   end

   // Offer one element and hold it until accepted. New bursts start after a
   // random gap (sometimes none), so valid drops only between bursts.
   task automatic push_element(logic signed [ELEM_W-1:0] value);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_element <= value;
      do @(posedge clock); while (!req_ready);
      board.take_element(value);
      elements_sent++;
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DW-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.set_register(index, value);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, let every expected beat come out and the block settle, then
   // load a new size. Both writes restart loading.
   task automatic resize(logic [CSR_DW-1:0] rows, logic [CSR_DW-1:0] cols);
      req_valid <= 1'b0;
      while (board.beats_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(REG_NUM_ROWS, rows);
      write_register(REG_NUM_COLS, cols);
      settings_used++;
   endtask

   initial begin
      logic [CSR_DW-1:0]        rows;
      logic [CSR_DW-1:0]        cols;
      logic signed [ELEM_W-1:0] value;
      int unsigned              random_items;
      int unsigned              phase;
      int unsigned              total;
      int unsigned              count;
      bit                       narrow;

      random_items = 0;
      phase = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sizes are zero out of reset: these beats must be swallowed.
      push_element(ELEM_MAX);
      push_element(ELEM_MIN);
      // Zero rows, then zero columns: still nothing comes back.
      resize(4'd0, 4'd3);
      push_element(32'sd17);
      resize(4'd5, 4'd0);
      push_element(-32'sd17);

      // 1x1: each element is its own matrix.
      resize(4'd1, 4'd1);
      push_element(ELEM_MAX);
      push_element(ELEM_MIN);

      // Single row comes back unchanged.
      resize(4'd1, 4'd4);
      push_element(ELEM_MIN);
      push_element(-32'sd1);
      push_element(32'sd0);
      push_element(ELEM_MAX);

      // Single column: keys are the elements, two of them equal.
      resize(4'd4, 4'd1);
      push_element(32'sd5);
      push_element(ELEM_MIN);
      push_element(32'sd5);
      push_element(ELEM_MAX);

      // Half-loaded 2x2, then a size write must throw the partial load away.
      resize(4'd2, 4'd2);
      push_element(32'sd3);
      push_element(32'sd7);
      // 3x2 with keys 1, 1, 5: the two tied rows swap order.
      resize(4'd3, 4'd2);
      push_element(32'sd1);
      push_element(32'sd4);
      push_element(32'sd6);
      push_element(32'sd1);
      push_element(32'sd5);
      push_element(32'sd9);

      // Random phases. The first one is oversized in its row count so that
      // clamping is hit early; most later ones are small matrices.
      while (random_items < RANDOM_ITEMS) begin
         case (phase == 0 ? 0 : $urandom_range(0, 19))
            0: begin
               rows = (phase == 0) ? 4'd15 : CSR_DW'($urandom_range(8, 15));
               cols = (phase == 0) ? 4'd8 : CSR_DW'($urandom_range(8, 15));
            end
            1: begin
               rows = 4'd0;
               cols = CSR_DW'($urandom_range(0, 15));
               if ($urandom_range(0, 1)) begin
                  rows = cols;
                  cols = 4'd0;
               end
            end
            2, 3: begin
               rows = CSR_DW'($urandom_range(1, 8));
               cols = CSR_DW'($urandom_range(1, 3));
            end
            default: begin
               rows = CSR_DW'($urandom_range(1, 4));
               cols = CSR_DW'($urandom_range(1, 4));
            end
         endcase
         resize(rows, cols);
         total = ((rows > MAX_ROWS) ? MAX_ROWS : rows) * ((cols > MAX_COLS) ? MAX_COLS : cols);
         narrow = ($urandom_range(0, 2) == 0);
         if (total == 0) begin
            count = $urandom_range(1, 3);
         end else begin
            count = total * ((total > 16) ? 1 : $urandom_range(1, 3));
            // Now and then leave a matrix half-loaded for the next size write.
            if (total > 1 && $urandom_range(0, 3) == 0) count += $urandom_range(1, total - 1);
            random_items += count;
         end
         repeat (count) begin
            if (narrow) begin
               // Tiny values make tied row minimums common.
               value = $urandom_range(0, 6) - 3;
            end else begin
               case ($urandom_range(0, 9))
                  0: value = ELEM_MIN;
                  1: value = ELEM_MAX;
                  2, 3: value = $urandom_range(0, 6) - 3;
                  default: value = $urandom;
               endcase
            end
            push_element(value);
         end
         phase++;
      end

      // Drain: wait out every expected beat, then watch for strays.
      req_valid <= 1'b0;
      while (board.beats_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d elements through %0d size settings (zero, clamped and tied keys included).",
               elements_sent, settings_used);
      $display("Sorted %0d matrices and checked %0d result beats.",
               board.matrices_sorted, board.beats_checked);
      if (board.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #(2_000_000);
      $display("Some tests failed");
      $finish;
   end
endmodule

[filelist.f]
+incdir+rtl
rtl/sortrm_pkg.sv
rtl/sort_rows_by_row_min_desc.sv
verif/sort_rows_by_row_min_desc_test.sv
